// ----- hw/rtl/rcpc_pkg.sv -----
// shared types and constants for the rounded corner pixel clip
`timescale 1ns / 1ps
`default_nettype none
package rcpc_pkg;

  // largest tile edge in pixels
  localparam int MAX_TILE   = 16;
  localparam int CNT_W      = $clog2(MAX_TILE);
  localparam int TILE_W     = 5;
  // compare width for tile limits, holds MAX_TILE and any 5 bit size
  localparam int CMP_W      = TILE_W + CNT_W;
  // button-relative position, signed
  localparam int POS_W      = 12;
  localparam int SCR_W      = 11;
  localparam int RGB_W      = 16;
  localparam int RAD_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFS_X  = 3'd0,
    CFG_OFS_Y  = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_HEIGHT = 3'd3,
    CFG_RADIUS = 3'd4,
    CFG_LEFT   = 3'd5,
    CFG_TOP    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0]       width;
    logic [8:0]       height;
    logic [RAD_W-1:0] radius;
    logic [9:0]       left;
    logic [9:0]       top;
  } geom_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] rx;
    logic [POS_W-1:0] ry;
    logic [RGB_W-1:0] rgb;
    logic             last;
  } pos_t;

  typedef struct packed {
    logic             in_rect;
    logic             corner;
    logic [RAD_W-1:0] dx;
    logic [RAD_W-1:0] dy;
    logic [SCR_W-1:0] sx;
    logic [SCR_W-1:0] sy;
    logic [RGB_W-1:0] rgb;
    logic             last;
  } geo_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rounded_corner_pixel_clip.sv -----
// top level: config registers, tile counters, position stage and corner clip
// path: an input transaction is registered in the position, geometry and result stages before the out_ ports
// throughput: one pixel per cycle, each stage moves on when the next is free
// in_stall rises only when all three stages hold data and out_stall is high
// reset (synchronous, rst_n low): pipeline empties, counters clear,
// registers return to offsets 0, size 100 x 100, radius 0, screen origin 0
`timescale 1ns / 1ps
`default_nettype none
module rounded_corner_pixel_clip
  import rcpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [9:0]            in_tile_origin_x,
  input  wire logic [9:0]            in_tile_origin_y,
  input  wire logic [TILE_W-1:0]     in_tile_cols,
  input  wire logic [TILE_W-1:0]     in_tile_rows,
  input  wire logic [RGB_W-1:0]      in_pixel_rgb,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_draw_enable,
  output logic [SCR_W-1:0]           out_screen_x,
  output logic [SCR_W-1:0]           out_screen_y,
  output logic [RGB_W-1:0]           out_rgb,
  output logic                       out_tile_last
);

  logic [8:0]       ofs_x_r;
  logic [8:0]       ofs_y_r;
  geom_cfg_t        geom_r;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic             pos_v_r;
  pos_t             pos_r;
  pos_t             pos_nxt;
  logic             pos_rdy, geo_rdy, accept;
  logic [CMP_W-1:0] lim_c, lim_r;
  logic             end_row, end_tile;

  function automatic logic [CMP_W-1:0] tile_limit(input logic [TILE_W-1:0] n);
    logic [CMP_W-1:0] w;
    w = CMP_W'(n);
    if (w == '0) begin
      w = CMP_W'(1);
    end else if (w > CMP_W'(MAX_TILE)) begin
      w = CMP_W'(MAX_TILE);
    end
    return w - CMP_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r       <= '0;
      ofs_y_r       <= '0;
      geom_r.width  <= 9'd100;
      geom_r.height <= 9'd100;
      geom_r.radius <= '0;
      geom_r.left   <= '0;
      geom_r.top    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFS_X:  ofs_x_r       <= cfg_wdata[8:0];
        CFG_OFS_Y:  ofs_y_r       <= cfg_wdata[8:0];
        CFG_WIDTH:  geom_r.width  <= cfg_wdata[8:0];
        CFG_HEIGHT: geom_r.height <= cfg_wdata[8:0];
        CFG_RADIUS: geom_r.radius <= cfg_wdata[RAD_W-1:0];
        CFG_LEFT:   geom_r.left   <= cfg_wdata;
        CFG_TOP:    geom_r.top    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pos_rdy  = !pos_v_r || geo_rdy;
  assign in_stall = !pos_rdy;
  assign accept   = in_valid && pos_rdy;

  // a counter at or past the limit ends the row even if the size shrank mid-tile
  always_comb begin
    lim_c    = tile_limit(in_tile_cols);
    lim_r    = tile_limit(in_tile_rows);
    end_row  = CMP_W'(col_r) >= lim_c;
    end_tile = end_row && (CMP_W'(row_r) >= lim_r);
    col_nxt  = end_row ? '0 : col_r + CNT_W'(1);
    row_nxt  = end_tile ? '0 : (end_row ? row_r + CNT_W'(1) : row_r);

    pos_nxt.rx   = {{(POS_W-9){ofs_x_r[8]}}, ofs_x_r}
                 + {{(POS_W-10){1'b0}}, in_tile_origin_x}
                 + {{(POS_W-CNT_W){1'b0}}, col_r};
    pos_nxt.ry   = {{(POS_W-9){ofs_y_r[8]}}, ofs_y_r}
                 + {{(POS_W-10){1'b0}}, in_tile_origin_y}
                 + {{(POS_W-CNT_W){1'b0}}, row_r};
    pos_nxt.rgb  = in_pixel_rgb;
    pos_nxt.last = end_tile;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      pos_v_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (pos_rdy) begin
        pos_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pos_rdy) begin
      pos_r <= pos_nxt;
    end
  end

  rcpc_corner u_corner (
    .clk             (clk),
    .rst_n           (rst_n),
    .pos_valid       (pos_v_r),
    .pos             (pos_r),
    .pos_rdy         (geo_rdy),
    .geom            (geom_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_draw_enable (out_draw_enable),
    .out_screen_x    (out_screen_x),
    .out_screen_y    (out_screen_y),
    .out_rgb         (out_rgb),
    .out_tile_last   (out_tile_last)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/rcpc_corner.sv -----
// rectangle and rounded corner test, two pipeline stages up to the result register
`timescale 1ns / 1ps
`default_nettype none
module rcpc_corner
  import rcpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pos_valid,
  input  wire pos_t             pos,
  output logic                  pos_rdy,
  input  wire geom_cfg_t        geom,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_draw_enable,
  output logic [SCR_W-1:0]      out_screen_x,
  output logic [SCR_W-1:0]      out_screen_y,
  output logic [RGB_W-1:0]      out_rgb,
  output logic                  out_tile_last
);

  localparam int GW = POS_W + 1;

  logic              geo_v_r;
  geo_t              geo_r;
  geo_t              geo_nxt;
  logic              geo_rdy;
  logic              res_rdy;

  logic              draw_nxt;
  logic              out_valid_r;
  logic              draw_r;
  logic [SCR_W-1:0]  sx_r;
  logic [SCR_W-1:0]  sy_r;
  logic [RGB_W-1:0]  rgb_r;
  logic              last_r;

  logic signed [GW-1:0] rxe, rye, bwe, bhe, re, one;
  logic signed [GW-1:0] dxw, dyw;
  logic                 left, right, top, bottom, in_x, in_y;
  logic [2*RAD_W-1:0]   sq_x, sq_y, r2;
  logic [2*RAD_W:0]     dist2;

  assign res_rdy = !out_valid_r || !out_stall;
  assign geo_rdy = !geo_v_r || res_rdy;
  assign pos_rdy = geo_rdy;

  // stage 2: position against rectangle and corner squares
  always_comb begin
    rxe    = $signed({pos.rx[POS_W-1], pos.rx});
    rye    = $signed({pos.ry[POS_W-1], pos.ry});
    bwe    = $signed({{(GW-9){1'b0}}, geom.width});
    bhe    = $signed({{(GW-9){1'b0}}, geom.height});
    re     = $signed({{(GW-RAD_W){1'b0}}, geom.radius});
    one    = $signed(GW'(1));
    left   = rxe < re;
    right  = rxe >= bwe - re;
    top    = rye < re;
    bottom = rye >= bhe - re;
    in_x   = !rxe[GW-1] && (rxe < bwe);
    in_y   = !rye[GW-1] && (rye < bhe);
    // corner priority reduces to: left form wins in x, top form wins in y
    dxw    = left ? (re - rxe) : (rxe - (bwe - one - re));
    dyw    = top  ? (re - rye) : (rye - (bhe - one - re));
    geo_nxt.in_rect = in_x && in_y;
    geo_nxt.corner  = (left || right) && (top || bottom);
    geo_nxt.dx      = dxw[RAD_W-1:0];
    geo_nxt.dy      = dyw[RAD_W-1:0];
    geo_nxt.sx      = SCR_W'(geom.left) + pos.rx[SCR_W-1:0];
    geo_nxt.sy      = SCR_W'(geom.top) + pos.ry[SCR_W-1:0];
    geo_nxt.rgb     = pos.rgb;
    geo_nxt.last    = pos.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_v_r <= 1'b0;
    end else if (geo_rdy) begin
      geo_v_r <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (geo_rdy) begin
      geo_r <= geo_nxt;
    end
  end

  // stage 3: squared distance against squared radius
  always_comb begin
    sq_x     = (2*RAD_W)'(geo_r.dx) * (2*RAD_W)'(geo_r.dx);
    sq_y     = (2*RAD_W)'(geo_r.dy) * (2*RAD_W)'(geo_r.dy);
    r2       = (2*RAD_W)'(geom.radius) * (2*RAD_W)'(geom.radius);
    dist2    = {1'b0, sq_x} + {1'b0, sq_y};
    draw_nxt = geo_r.in_rect && (!geo_r.corner || (dist2 <= {1'b0, r2}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_rdy) begin
      out_valid_r <= geo_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_rdy) begin
      draw_r <= draw_nxt;
      sx_r   <= draw_nxt ? geo_r.sx : '0;
      sy_r   <= draw_nxt ? geo_r.sy : '0;
      rgb_r  <= geo_r.rgb;
      last_r <= geo_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_draw_enable = draw_r;
  assign out_screen_x    = sx_r;
  assign out_screen_y    = sy_r;
  assign out_rgb         = rgb_r;
  assign out_tile_last   = last_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rcpc_checker.sv -----
// port-level checks for the rounded corner pixel clip, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module rcpc_checker
  import rcpc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             out_draw_enable,
  input wire logic [SCR_W-1:0] out_screen_x,
  input wire logic [SCR_W-1:0] out_screen_y,
  input wire logic [RGB_W-1:0] out_rgb
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a dropped pixel carries a zero screen position
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_draw_enable |-> out_screen_x == '0 && out_screen_y == '0)
    else $error("dropped pixel with nonzero screen position");

  // input backpressure only when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  // an idle input that is not stalled cannot be stalled in the following cycle
  a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !in_stall |=> !in_stall)
    else $error("input stalled after an idle cycle");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rgb)
      && $stable(out_screen_x) && $stable(out_draw_enable))
    else $error("stalled result changed");

endmodule

bind rounded_corner_pixel_clip rcpc_checker u_rcpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_draw_enable (out_draw_enable),
  .out_screen_x    (out_screen_x),
  .out_screen_y    (out_screen_y),
  .out_rgb         (out_rgb)
);
`default_nettype wire
